@@ hdl/q15sc_pkg.sv @@
// ----------------------------------------------------------------------------
// q15sc_pkg
// Shared types, coefficients and the normalized Q15 multiply for the
// sine/cosine polynomial pipeline.
// ----------------------------------------------------------------------------
package q15sc_pkg;

    localparam int W = 16;

    // polynomial coefficients
    localparam logic signed [W-1:0] C_LIN  = 16'sd18705;
    localparam logic signed [W-1:0] C_C3   = -16'sd21166;
    localparam logic signed [W-1:0] C_C5   = 16'sd2611;
    localparam logic signed [W-1:0] C_C7   = -16'sd152;
    localparam logic signed [W-1:0] C_K2   = -16'sd7656;
    localparam logic signed [W-1:0] C_K8   = 16'sd30;
    localparam logic signed [W-1:0] C_K4   = 16'sd8311;
    localparam logic signed [W-1:0] C_K6   = -16'sd683;
    localparam logic signed [W-1:0] C_ONE  = 16'sd32767;

    // edge correction terms for phase -32768
    localparam logic signed [W-1:0] CORR_COS   = -16'sd57;
    localparam logic signed [W-1:0] CORR_SIN   = -16'sd28123;
    localparam logic [W-1:0]        PHASE_EDGE = 16'h8000;

    // stage 1: products of the phase
    typedef struct packed {
        logic [W-1:0] ph;
        logic [W-1:0] sq;
        logic [W-1:0] lin;
        logic [W-1:0] c3;
        logic [W-1:0] c5;
        logic [W-1:0] c7;
        logic         corr;
    } t_st1;

    // stage 2: products of the square
    typedef struct packed {
        logic [W-1:0] s;
        logic [W-1:0] c;
        logic [W-1:0] sq;
        logic [W-1:0] quad;
        logic [W-1:0] s3;
        logic [W-1:0] k2;
        logic [W-1:0] c5;
        logic [W-1:0] c7;
        logic         corr;
    } t_st2;

    // stage 3: products of the fourth power
    typedef struct packed {
        logic [W-1:0] s;
        logic [W-1:0] c;
        logic [W-1:0] quad;
        logic [W-1:0] hex;
        logic [W-1:0] s5;
        logic [W-1:0] k8c;
        logic [W-1:0] k4;
        logic [W-1:0] c7;
        logic         corr;
    } t_st3;

    // stage 4: last products
    typedef struct packed {
        logic [W-1:0] s;
        logic [W-1:0] c;
        logic [W-1:0] k6;
        logic [W-1:0] s7;
        logic [W-1:0] k8;
    } t_st4;

    // ((a*b >> 14) + 1) >> 1, kept to 16 bits
    function automatic logic [W-1:0] qmul(input logic signed [W-1:0] a,
                                          input logic signed [W-1:0] b);
        logic signed [2*W-1:0] p;
        logic [2*W-1:0]        u;
        p = (2*W)'(a) * (2*W)'(b);
        u = p + 32'd16384;
        return u[2*W-2:W-1];
    endfunction

endpackage

@@ hdl/q15sc_front.sv @@
// ----------------------------------------------------------------------------
// q15sc_front
// Stages 1 and 2: products of the phase, then products of its square.
// ----------------------------------------------------------------------------
module q15sc_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [15:0]        i_phase,
    input  logic               i_corr_en,
    output logic               o_valid,
    input  logic               i_ready,
    output q15sc_pkg::t_st2    o_data
);

    logic            r_vld1, r_vld2;
    logic            w_rdy1, w_rdy2;
    q15sc_pkg::t_st1 r_st1, n_st1;
    q15sc_pkg::t_st2 r_st2, n_st2;

    assign w_rdy2  = !r_vld2 || i_ready;
    assign w_rdy1  = !r_vld1 || w_rdy2;
    assign o_ready = w_rdy1;
    assign o_valid = r_vld2;
    assign o_data  = r_st2;

    always_comb begin
        n_st1.ph   = i_phase;
        n_st1.sq   = q15sc_pkg::qmul(i_phase, i_phase);
        n_st1.lin  = q15sc_pkg::qmul(i_phase, q15sc_pkg::C_LIN);
        n_st1.c3   = q15sc_pkg::qmul(i_phase, q15sc_pkg::C_C3);
        n_st1.c5   = q15sc_pkg::qmul(i_phase, q15sc_pkg::C_C5);
        n_st1.c7   = q15sc_pkg::qmul(i_phase, q15sc_pkg::C_C7);
        n_st1.corr = i_corr_en && (i_phase == q15sc_pkg::PHASE_EDGE);
    end

    always_comb begin
        n_st2.s    = r_st1.ph + r_st1.lin;
        n_st2.c    = q15sc_pkg::C_ONE - r_st1.sq;
        n_st2.sq   = r_st1.sq;
        n_st2.quad = q15sc_pkg::qmul(r_st1.sq, r_st1.sq);
        n_st2.s3   = q15sc_pkg::qmul(r_st1.sq, r_st1.c3);
        n_st2.k2   = q15sc_pkg::qmul(r_st1.sq, q15sc_pkg::C_K2);
        n_st2.c5   = r_st1.c5;
        n_st2.c7   = r_st1.c7;
        n_st2.corr = r_st1.corr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            if (w_rdy1) r_vld1 <= i_valid;
            if (w_rdy2) r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) r_st1 <= n_st1;
        if (w_rdy2 && r_vld1)  r_st2 <= n_st2;
    end

endmodule

@@ hdl/q15sc_back.sv @@
// ----------------------------------------------------------------------------
// q15sc_back
// Stages 3 and 4: products of the fourth and sixth powers, partial sums.
// ----------------------------------------------------------------------------
module q15sc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  q15sc_pkg::t_st2    i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output q15sc_pkg::t_st4    o_data
);

    logic            r_vld3, r_vld4;
    logic            w_rdy3, w_rdy4;
    q15sc_pkg::t_st3 r_st3, n_st3;
    q15sc_pkg::t_st4 r_st4, n_st4;

    assign w_rdy4  = !r_vld4 || i_ready;
    assign w_rdy3  = !r_vld3 || w_rdy4;
    assign o_ready = w_rdy3;
    assign o_valid = r_vld4;
    assign o_data  = r_st4;

    always_comb begin
        n_st3.s    = i_data.s + i_data.s3;
        n_st3.c    = i_data.c + i_data.k2;
        n_st3.quad = i_data.quad;
        n_st3.hex  = q15sc_pkg::qmul(i_data.quad, i_data.sq);
        n_st3.s5   = q15sc_pkg::qmul(i_data.quad, i_data.c5);
        n_st3.k8c  = q15sc_pkg::qmul(i_data.quad, q15sc_pkg::C_K8);
        n_st3.k4   = q15sc_pkg::qmul(i_data.quad, q15sc_pkg::C_K4);
        n_st3.c7   = i_data.c7;
        n_st3.corr = i_data.corr;
    end

    always_comb begin
        // correction lands before the seventh/sixth order terms
        n_st4.s  = r_st3.s + r_st3.s5 + (r_st3.corr ? q15sc_pkg::CORR_SIN : 16'd0);
        n_st4.c  = r_st3.c + r_st3.k4 + (r_st3.corr ? q15sc_pkg::CORR_COS : 16'd0);
        n_st4.k6 = q15sc_pkg::qmul(r_st3.hex, q15sc_pkg::C_K6);
        n_st4.s7 = q15sc_pkg::qmul(r_st3.hex, r_st3.c7);
        n_st4.k8 = q15sc_pkg::qmul(r_st3.quad, r_st3.k8c);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
        end else begin
            if (w_rdy3) r_vld3 <= i_valid;
            if (w_rdy4) r_vld4 <= r_vld3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3 && i_valid) r_st3 <= n_st3;
        if (w_rdy4 && r_vld3)  r_st4 <= n_st4;
    end

endmodule

@@ hdl/q15_sine_cosine_polynomial_top.sv @@
// ----------------------------------------------------------------------------
// q15_sine_cosine_polynomial_top
// Q15 sine and cosine of a 16-bit phase by fixed polynomials.
// ----------------------------------------------------------------------------
// Takes one phase per clock, when the master side does not stall, through
// a five-stage pipeline: four multiply stages (powers of the phase and their
// coefficient products, one multiply deep each) and an output register
// holding the final sums. Each phase passes stages 1 to 4 and then the
// output register before the master port. Without a stall, throughput is one
// transaction per cycle; every stage holds its own valid bit, so a stall on
// the master side fills bubbles before pushing back on the slave side. The
// edge correction mode is written through the cfg channel, which is always
// ready; write it only while no transaction is in flight.
module q15_sine_cosine_polynomial_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,      // edge_correction_enable
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,    // [15:0] phase
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata     // [15:0] sine, [31:16] cosine
);

    logic            r_corr_en;
    logic            w_f_vld, w_b_rdy, w_b_vld, w_o_rdy;
    q15sc_pkg::t_st2 w_f_data;
    q15sc_pkg::t_st4 w_b_data;
    logic            r_vld5;
    logic [15:0]     r_sine, r_cosine;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corr_en <= 1'b0;
        end else if (i_cfg_valid) begin
            r_corr_en <= i_cfg_data;
        end
    end

    q15sc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_phase   (s_axis_tdata),
        .i_corr_en (r_corr_en),
        .o_valid   (w_f_vld),
        .i_ready   (w_b_rdy),
        .o_data    (w_f_data)
    );

    q15sc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_vld),
        .o_ready (w_b_rdy),
        .i_data  (w_f_data),
        .o_valid (w_b_vld),
        .i_ready (w_o_rdy),
        .o_data  (w_b_data)
    );

    assign w_o_rdy = !r_vld5 || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld5 <= 1'b0;
        end else if (w_o_rdy) begin
            r_vld5 <= w_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_o_rdy && w_b_vld) begin
            r_sine   <= w_b_data.s + w_b_data.s7;
            r_cosine <= w_b_data.c + w_b_data.k6 + w_b_data.k8;
        end
    end

    assign m_axis_tvalid = r_vld5;
    assign m_axis_tdata  = {r_cosine, r_sine};

endmodule
